// ----- rtl/core/utrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_pkg: shared types for the UART transmit/receive ring buffers
// Operation codes, status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package utrb_pkg;

  // Operation carried by one input beat.
  typedef enum logic [1:0] {
    FN_WRITE    = 2'd0,
    FN_READ     = 2'd1,
    FN_TX_READY = 2'd2,
    FN_RX_BYTE  = 2'd3
  } func_t;

  // Status reported with each result beat.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TX_FULL  = 3'd1,
    ST_RX_EMPTY = 3'd2,
    ST_RX_DROP  = 3'd3,
    ST_TX_IDLE  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input beat and read both stores
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

// ----- rtl/core/utrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_ctrl: sequencing controller
// Accepts one beat, then issues the execute step once the result register
// is free.
// ----------------------------------------------------------------------------
module utrb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  output utrb_pkg::cmd_t cmd
);
  import utrb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold here while an earlier result still sits unclaimed.
        if (!out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/utrb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_datapath: ring queues, counters, restart flag and result register
// Two byte stores with registered reads, wrap counters one bit wider than
// the index, and the output register of the result channel.
// ----------------------------------------------------------------------------
module utrb_datapath #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  utrb_pkg::cmd_t    cmd,
  input  utrb_pkg::func_t   in_func,
  input  logic [7:0]        in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_busy,
  output utrb_pkg::status_t out_status,
  output logic [7:0]        out_data,
  output logic              out_tx_valid,
  output logic              out_kick
);
  import utrb_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_CW = TX_AW + 1;
  localparam int RX_CW = RX_AW + 1;

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  func_t      func_r;
  logic [7:0] data_r;
  logic [7:0] tx_rdata_r;
  logic [7:0] rx_rdata_r;

  logic [TX_CW-1:0] tx_wr_cnt_r, tx_wr_cnt_nxt;
  logic [TX_CW-1:0] tx_rd_cnt_r, tx_rd_cnt_nxt;
  logic [RX_CW-1:0] rx_wr_cnt_r, rx_wr_cnt_nxt;
  logic [RX_CW-1:0] rx_rd_cnt_r, rx_rd_cnt_nxt;
  logic             restart_r, restart_nxt;
  logic             out_valid_r, out_valid_nxt;

  status_t    status_r, status_nxt;
  logic [7:0] dout_r, dout_nxt;
  logic       txv_r, txv_nxt;
  logic       kick_r, kick_nxt;

  logic tx_we;
  logic rx_we;
  logic tx_full, tx_empty, rx_full, rx_empty;

  // Full when the wrap bits differ and the indexes match.
  assign tx_empty = (tx_wr_cnt_r == tx_rd_cnt_r);
  assign rx_empty = (rx_wr_cnt_r == rx_rd_cnt_r);
  assign tx_full  = (tx_wr_cnt_r[TX_AW] != tx_rd_cnt_r[TX_AW]) &&
                    (tx_wr_cnt_r[TX_AW-1:0] == tx_rd_cnt_r[TX_AW-1:0]);
  assign rx_full  = (rx_wr_cnt_r[RX_AW] != rx_rd_cnt_r[RX_AW]) &&
                    (rx_wr_cnt_r[RX_AW-1:0] == rx_rd_cnt_r[RX_AW-1:0]);

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_cnt_r[TX_AW-1:0]] <= data_r;
    end
    if (cmd.capture) begin
      tx_rdata_r <= tx_mem[tx_rd_cnt_r[TX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_cnt_r[RX_AW-1:0]] <= data_r;
    end
    if (cmd.capture) begin
      rx_rdata_r <= rx_mem[rx_rd_cnt_r[RX_AW-1:0]];
    end
  end

  always_comb begin
    tx_we         = 1'b0;
    rx_we         = 1'b0;
    tx_wr_cnt_nxt = tx_wr_cnt_r;
    tx_rd_cnt_nxt = tx_rd_cnt_r;
    rx_wr_cnt_nxt = rx_wr_cnt_r;
    rx_rd_cnt_nxt = rx_rd_cnt_r;
    restart_nxt   = restart_r;
    status_nxt    = ST_OK;
    dout_nxt      = 8'd0;
    txv_nxt       = 1'b0;
    kick_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      case (func_r)
        FN_WRITE: begin
          if (tx_full) begin
            status_nxt = ST_TX_FULL;
          end else begin
            tx_we         = 1'b1;
            tx_wr_cnt_nxt = tx_wr_cnt_r + TX_CW'(1);
            if (restart_r) begin
              restart_nxt = 1'b0;
              kick_nxt    = 1'b1;
            end
          end
        end
        FN_READ: begin
          if (rx_empty) begin
            status_nxt = ST_RX_EMPTY;
          end else begin
            dout_nxt      = rx_rdata_r;
            rx_rd_cnt_nxt = rx_rd_cnt_r + RX_CW'(1);
          end
        end
        FN_TX_READY: begin
          if (tx_empty) begin
            restart_nxt = 1'b1;
            status_nxt  = ST_TX_IDLE;
          end else begin
            dout_nxt      = tx_rdata_r;
            tx_rd_cnt_nxt = tx_rd_cnt_r + TX_CW'(1);
            restart_nxt   = 1'b0;
            txv_nxt       = 1'b1;
          end
        end
        FN_RX_BYTE: begin
          if (rx_full) begin
            status_nxt = ST_RX_DROP;
          end else begin
            rx_we         = 1'b1;
            rx_wr_cnt_nxt = rx_wr_cnt_r + RX_CW'(1);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_cnt_r <= '0;
      tx_rd_cnt_r <= '0;
      rx_wr_cnt_r <= '0;
      rx_rd_cnt_r <= '0;
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      tx_wr_cnt_r <= tx_wr_cnt_nxt;
      tx_rd_cnt_r <= tx_rd_cnt_nxt;
      rx_wr_cnt_r <= rx_wr_cnt_nxt;
      rx_rd_cnt_r <= rx_rd_cnt_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      data_r <= in_data;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
      txv_r    <= txv_nxt;
      kick_r   <= kick_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_busy     = out_valid_r && !out_ready;
  assign out_status   = status_r;
  assign out_data     = dout_r;
  assign out_tx_valid = txv_r;
  assign out_kick     = kick_r;

endmodule

// ----- rtl/core/uart_tx_rx_ring_buffers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers: transmit and receive ring queues of a serial port
// Software writes and reads, transmitter-ready events and received bytes,
// one per input beat, each answered by exactly one result beat.
// ----------------------------------------------------------------------------
// Each input beat has a capture step and an execute step. In the capture step
// the beat is captured and both byte stores are read at their read counters
// (the store reads are registered); in the execute step the operation updates
// the counters, the restart flag and the stores and loads the result register.
// The result register parts the two channels, so the next beat is accepted
// while a result still waits; if it is still not taken, the new beat waits
// before its execute step until the result register frees up. After reset the
// transmit restart flag is set, both queues are empty, and no clearing pass is
// run over the stores. TX_DEPTH and RX_DEPTH must be powers of two.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_out
  output logic [4:0] out_tuser   // [2:0] status, [3] tx_valid, [4] kick
);
  import utrb_pkg::*;

  cmd_t    cmd;
  logic    out_busy;
  status_t status;
  logic    tx_valid;
  logic    kick;

  // The controller only sequences; all state of the queues is in the datapath.
  utrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  utrb_datapath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (func_t'(in_tuser)),
    .in_data      (in_tdata),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_busy     (out_busy),
    .out_status   (status),
    .out_data     (out_tdata),
    .out_tx_valid (tx_valid),
    .out_kick     (kick)
  );

  assign out_tuser = {kick, tx_valid, status};

  // An accepted beat is never followed by another acceptance in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while the previous beat was still executing");

  // The execute step always leaves a result waiting.
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid)
    else $error("execute step produced no result beat");

  // A kick and a transmitted byte come from different operations.
  a_kick_txv_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(kick && tx_valid))
    else $error("kick and tx_valid raised in the same result");

  // A kick or a transmitted byte only comes with an ok status.
  a_flags_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (kick || tx_valid)) |-> (status == ST_OK))
    else $error("kick or tx_valid raised with an error status");

endmodule
